>>> rtl/core/lbmf_pkg.sv
// Package: shared types, constants and Morse lookup functions for the Morse flasher.
package lbmf_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_LINE_DEPTH = 1024;
    localparam int DEF_TICK_WIDTH = 16;

    // Configuration registers
    localparam int                 DUR_W          = 16;
    localparam int                 CFG_IDX_W      = 1;
    localparam logic [DUR_W-1:0]   DEF_DOT_TICKS  = 16'd500;
    localparam logic [DUR_W-1:0]   DEF_DASH_TICKS = 16'd1500;
    localparam logic [CFG_IDX_W-1:0] CFG_DOT_TICKS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DASH_TICKS = 1'b1;

    // Item opcodes
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Line terminators
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    // Longest Morse symbol, in elements
    localparam logic [2:0] MORSE_MAX = 3'd5;

    typedef struct packed {
        logic       opcode;
        logic [7:0] char_code;
    } lbmf_in_t;

    typedef struct packed {
        logic led_level;
        logic playing;
        logic line_overflow;
    } lbmf_out_t;

    // Control from the sequencer to the line store pair
    typedef struct packed {
        logic wr_en;     // write the pending store
        logic rd_en;     // read the playing store
        logic pend_sel;  // which store holds the pending line
    } lbmf_store_ctl_t;

    typedef struct packed {
        logic       valid;
        logic [5:0] idx;
    } lbmf_code_t;

    typedef struct packed {
        logic [2:0] len;   // number of elements
        logic [4:0] dash;  // bit i set: element i is a dash
    } lbmf_morse_t;

    // Character byte to table index; letters are case folded
    function automatic lbmf_code_t code_index(input logic [7:0] c);
        lbmf_code_t r;
        logic [7:0] f;
        f = c;
        if (c >= 8'h41 && c <= 8'h5A)
            f = c + 8'd32;
        r.valid = 1'b0;
        r.idx   = 6'd0;
        if (f >= 8'h61 && f <= 8'h7A) begin
            r.valid = 1'b1;
            r.idx   = 6'(f - 8'h61);
        end
        else if (f >= 8'h31 && f <= 8'h39) begin
            r.valid = 1'b1;
            r.idx   = 6'(f - 8'h31) + 6'd26;
        end
        else if (f == 8'h30) begin
            r.valid = 1'b1;
            r.idx   = 6'd35;
        end
        return r;
    endfunction

    // International Morse table: a-z, then 1-9, then 0
    function automatic lbmf_morse_t morse_code(input logic [5:0] k);
        lbmf_morse_t m;
        case (k)
            6'd0:    m = '{3'd2, 5'b00010};  // a
            6'd1:    m = '{3'd4, 5'b00001};  // b
            6'd2:    m = '{3'd4, 5'b00101};  // c
            6'd3:    m = '{3'd3, 5'b00001};  // d
            6'd4:    m = '{3'd1, 5'b00000};  // e
            6'd5:    m = '{3'd4, 5'b00100};  // f
            6'd6:    m = '{3'd3, 5'b00011};  // g
            6'd7:    m = '{3'd4, 5'b00000};  // h
            6'd8:    m = '{3'd2, 5'b00000};  // i
            6'd9:    m = '{3'd4, 5'b01110};  // j
            6'd10:   m = '{3'd3, 5'b00101};  // k
            6'd11:   m = '{3'd4, 5'b00010};  // l
            6'd12:   m = '{3'd2, 5'b00011};  // m
            6'd13:   m = '{3'd2, 5'b00001};  // n
            6'd14:   m = '{3'd3, 5'b00111};  // o
            6'd15:   m = '{3'd4, 5'b00110};  // p
            6'd16:   m = '{3'd4, 5'b01011};  // q
            6'd17:   m = '{3'd3, 5'b00010};  // r
            6'd18:   m = '{3'd3, 5'b00000};  // s
            6'd19:   m = '{3'd1, 5'b00001};  // t
            6'd20:   m = '{3'd3, 5'b00100};  // u
            6'd21:   m = '{3'd4, 5'b01000};  // v
            6'd22:   m = '{3'd3, 5'b00110};  // w
            6'd23:   m = '{3'd4, 5'b01001};  // x
            6'd24:   m = '{3'd4, 5'b01101};  // y
            6'd25:   m = '{3'd4, 5'b00011};  // z
            6'd26:   m = '{3'd5, 5'b11110};  // 1
            6'd27:   m = '{3'd5, 5'b11100};  // 2
            6'd28:   m = '{3'd5, 5'b11000};  // 3
            6'd29:   m = '{3'd5, 5'b10000};  // 4
            6'd30:   m = '{3'd5, 5'b00000};  // 5
            6'd31:   m = '{3'd5, 5'b00001};  // 6
            6'd32:   m = '{3'd5, 5'b00011};  // 7
            6'd33:   m = '{3'd5, 5'b00111};  // 8
            6'd34:   m = '{3'd5, 5'b01111};  // 9
            6'd35:   m = '{3'd5, 5'b11111};  // 0
            default: m = '{3'd0, 5'b00000};
        endcase
        return m;
    endfunction

endpackage

>>> rtl/core/lbmf_ram.sv
// Generic single-port RAM with registered read data.
module lbmf_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [DATA_W-1:0]        wdata,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // One access per cycle, read data valid the next cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

>>> rtl/core/lbmf_line_store.sv
// Line store pair: pending line is written to one store while the other is played.
module lbmf_line_store #(
    parameter int LINE_DEPTH = lbmf_pkg::DEF_LINE_DEPTH
) (
    input  logic                          clk,
    input  lbmf_pkg::lbmf_store_ctl_t     ctl,
    input  logic [$clog2(LINE_DEPTH)-1:0] wr_addr,
    input  logic [7:0]                    wr_data,
    input  logic [$clog2(LINE_DEPTH)-1:0] rd_addr,
    output logic [7:0]                    rd_data
);
    import lbmf_pkg::*;

    localparam int ADDR_W = $clog2(LINE_DEPTH);

    logic              we_a;
    logic              we_b;
    logic              re_a;
    logic              re_b;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [7:0]        rdata_a;
    logic [7:0]        rdata_b;
    logic              rd_sel_reg;

    // Writes go to the pending store, reads to the other one
    assign we_a   = ctl.wr_en & ~ctl.pend_sel;
    assign we_b   = ctl.wr_en &  ctl.pend_sel;
    assign re_a   = ctl.rd_en &  ctl.pend_sel;
    assign re_b   = ctl.rd_en & ~ctl.pend_sel;
    assign addr_a = we_a ? wr_addr : rd_addr;
    assign addr_b = we_b ? wr_addr : rd_addr;

    lbmf_ram #(
        .DATA_W (8),
        .DEPTH  (LINE_DEPTH)
    ) u_store_a (
        .clk   (clk),
        .we    (we_a),
        .re    (re_a),
        .addr  (addr_a),
        .wdata (wr_data),
        .rdata (rdata_a)
    );

    lbmf_ram #(
        .DATA_W (8),
        .DEPTH  (LINE_DEPTH)
    ) u_store_b (
        .clk   (clk),
        .we    (we_b),
        .re    (re_b),
        .addr  (addr_b),
        .wdata (wr_data),
        .rdata (rdata_b)
    );

    // Remember which store was read for the data cycle
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_sel_reg <= ~ctl.pend_sel;
        end
    end

    assign rd_data = rd_sel_reg ? rdata_b : rdata_a;

endmodule

>>> rtl/core/line_buffered_morse_flasher.sv
// Top level: line-buffered Morse flasher, command interface and playback sequencer.
// Each word gives one result word, strobed on done the cycle after its accept or last busy cycle.
// A character word or a tick inside an element keeps busy low: a new word may start next cycle.
// A tick at an element boundary reads the playing line one stored character per cycle, with busy
// high while characters are examined, at most LINE_DEPTH of them.
// Results cannot be held off. Reset clears control state and presets durations; stores are kept.
module line_buffered_morse_flasher #(
    parameter int LINE_DEPTH = lbmf_pkg::DEF_LINE_DEPTH,
    parameter int TICK_WIDTH = lbmf_pkg::DEF_TICK_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  lbmf_pkg::lbmf_in_t                 item,
    output logic                               done,
    output lbmf_pkg::lbmf_out_t                result,
    input  logic                               cfg_wr_en,
    input  logic [lbmf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lbmf_pkg::DUR_W-1:0]         cfg_data
);
    import lbmf_pkg::*;

    localparam int ADDR_W = $clog2(LINE_DEPTH);
    localparam int LEN_W  = $clog2(LINE_DEPTH + 1);
    localparam int LW     = (TICK_WIDTH > DUR_W) ? TICK_WIDTH : DUR_W;
    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(LINE_DEPTH);
    localparam logic [LW-1:0]    CNT_MAX  = LW'((33'd1 << TICK_WIDTH) - 33'd1);

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_LIT  = 3'b010,
        PH_DARK = 3'b100
    } phase_t;

    typedef enum logic [1:0] {
        CTL_IDLE = 2'b01,
        CTL_EVAL = 2'b10
    } ctl_t;

    // Element duration in counter ticks: zero counts as one, saturate to the counter
    function automatic logic [TICK_WIDTH-1:0] phase_load(input logic [DUR_W-1:0] dur);
        logic [DUR_W-1:0] dm1;
        logic [LW-1:0]    wide;
        dm1  = (dur == '0) ? '0 : dur - DUR_W'(1);
        wide = LW'(dm1);
        if (wide > CNT_MAX)
            wide = CNT_MAX;
        return TICK_WIDTH'(wide);
    endfunction

    logic [DUR_W-1:0]      dot_ticks_reg;
    logic [DUR_W-1:0]      dash_ticks_reg;
    logic                  pend_sel_reg,      pend_sel_next;
    logic [LEN_W-1:0]      pend_len_reg,      pend_len_next;
    logic [LEN_W-1:0]      play_len_reg,      play_len_next;
    logic [LEN_W-1:0]      play_pos_reg,      play_pos_next;
    logic [2:0]            elem_idx_reg,      elem_idx_next;
    phase_t                phase_reg,         phase_next;
    logic [TICK_WIDTH-1:0] countdown_reg,     countdown_next;
    logic                  restart_reg,       restart_next;
    logic                  is_dash_reg,       is_dash_next;
    ctl_t                  ctl_reg,           ctl_next;
    logic                  done_reg,          done_next;
    lbmf_out_t             result_reg,        result_next;

    lbmf_store_ctl_t       store_ctl;
    logic [ADDR_W-1:0]     rd_addr;
    logic [7:0]            rd_data;
    logic                  accept;
    logic                  overflow;
    logic                  walk;
    logic [LEN_W-1:0]      walk_pos;
    logic [LEN_W-1:0]      next_pos;
    lbmf_code_t            ci;
    lbmf_morse_t           mc;
    logic                  hit;
    logic                  hit_dash;

    assign accept = start & ~busy;
    assign busy   = (ctl_reg != CTL_IDLE);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_ticks_reg  <= DEF_DOT_TICKS;
            dash_ticks_reg <= DEF_DASH_TICKS;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_DOT_TICKS:  dot_ticks_reg  <= cfg_data;
                CFG_DASH_TICKS: dash_ticks_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Decode of the character read from the playing store
    always_comb
    begin
        ci       = code_index(rd_data);
        mc       = morse_code(ci.idx);
        hit      = ci.valid && (elem_idx_reg < MORSE_MAX) && (elem_idx_reg < mc.len);
        hit_dash = (elem_idx_reg < MORSE_MAX) ? mc.dash[elem_idx_reg] : 1'b0;
    end

    // Sequencer
    always_comb
    begin
        pend_sel_next  = pend_sel_reg;
        pend_len_next  = pend_len_reg;
        play_len_next  = play_len_reg;
        play_pos_next  = play_pos_reg;
        elem_idx_next  = elem_idx_reg;
        phase_next     = phase_reg;
        countdown_next = countdown_reg;
        restart_next   = restart_reg;
        is_dash_next   = is_dash_reg;
        ctl_next       = ctl_reg;
        done_next      = 1'b0;
        overflow       = 1'b0;
        walk           = 1'b0;
        walk_pos       = play_pos_reg;
        next_pos       = play_pos_reg + LEN_W'(1);
        store_ctl      = '{wr_en: 1'b0, rd_en: 1'b0, pend_sel: pend_sel_reg};
        rd_addr        = play_pos_reg[ADDR_W-1:0];

        case (ctl_reg)
            CTL_IDLE:
            begin
                if (accept)
                begin
                    if (item.opcode == OP_CHAR)
                    begin
                        done_next = 1'b1;
                        if (item.char_code == CH_LF || item.char_code == CH_CR)
                        begin
                            play_len_next = pend_len_reg;
                            pend_len_next = '0;
                            pend_sel_next = ~pend_sel_reg;
                            restart_next  = 1'b1;
                        end
                        else if (pend_len_reg < LEN_FULL)
                        begin
                            store_ctl.wr_en = 1'b1;
                            pend_len_next   = pend_len_reg + LEN_W'(1);
                        end
                        else
                        begin
                            overflow = 1'b1;
                        end
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_LIT:
                            begin
                                done_next = 1'b1;
                                if (countdown_reg != '0)
                                begin
                                    countdown_next = countdown_reg - TICK_WIDTH'(1);
                                end
                                else
                                begin
                                    phase_next     = PH_DARK;
                                    countdown_next = phase_load(is_dash_reg ? dash_ticks_reg
                                                                            : dot_ticks_reg);
                                end
                            end
                            PH_DARK:
                            begin
                                if (countdown_reg != '0)
                                begin
                                    done_next      = 1'b1;
                                    countdown_next = countdown_reg - TICK_WIDTH'(1);
                                end
                                else
                                begin
                                    walk          = 1'b1;
                                    elem_idx_next = elem_idx_reg + 3'd1;
                                end
                            end
                            default:
                            begin
                                walk = 1'b1;
                            end
                        endcase

                        // Element boundary: apply a restart, fetch this character or end playback
                        if (walk)
                        begin
                            if (restart_reg)
                            begin
                                walk_pos      = '0;
                                elem_idx_next = '0;
                            end
                            restart_next  = 1'b0;
                            play_pos_next = walk_pos;
                            if (walk_pos < play_len_reg)
                            begin
                                store_ctl.rd_en = 1'b1;
                                rd_addr         = walk_pos[ADDR_W-1:0];
                                ctl_next        = CTL_EVAL;
                            end
                            else
                            begin
                                phase_next     = PH_IDLE;
                                elem_idx_next  = '0;
                                countdown_next = '0;
                                done_next      = 1'b1;
                            end
                        end
                    end
                end
            end

            CTL_EVAL:
            begin
                if (hit)
                begin
                    // Start lighting the element
                    phase_next     = PH_LIT;
                    is_dash_next   = hit_dash;
                    countdown_next = phase_load(hit_dash ? dash_ticks_reg : dot_ticks_reg);
                    ctl_next       = CTL_IDLE;
                    done_next      = 1'b1;
                end
                else
                begin
                    // Skip to the next character of the line, or end playback past its end
                    play_pos_next = next_pos;
                    elem_idx_next = '0;
                    if (next_pos < play_len_reg)
                    begin
                        store_ctl.rd_en = 1'b1;
                        rd_addr         = next_pos[ADDR_W-1:0];
                    end
                    else
                    begin
                        phase_next     = PH_IDLE;
                        countdown_next = '0;
                        ctl_next       = CTL_IDLE;
                        done_next      = 1'b1;
                    end
                end
            end

            default:
            begin
                ctl_next = CTL_IDLE;
            end
        endcase

        result_next.led_level     = (phase_next == PH_LIT);
        result_next.playing       = (phase_next != PH_IDLE);
        result_next.line_overflow = overflow;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_sel_reg  <= 1'b0;
            pend_len_reg  <= '0;
            play_len_reg  <= '0;
            play_pos_reg  <= '0;
            elem_idx_reg  <= '0;
            phase_reg     <= PH_IDLE;
            countdown_reg <= '0;
            restart_reg   <= 1'b0;
            is_dash_reg   <= 1'b0;
            ctl_reg       <= CTL_IDLE;
            done_reg      <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            pend_sel_reg  <= pend_sel_next;
            pend_len_reg  <= pend_len_next;
            play_len_reg  <= play_len_next;
            play_pos_reg  <= play_pos_next;
            elem_idx_reg  <= elem_idx_next;
            phase_reg     <= phase_next;
            countdown_reg <= countdown_next;
            restart_reg   <= restart_next;
            is_dash_reg   <= is_dash_next;
            ctl_reg       <= ctl_next;
            done_reg      <= done_next;
            result_reg    <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Pending and playing line stores
    lbmf_line_store #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_line_store (
        .clk     (clk),
        .ctl     (store_ctl),
        .wr_addr (pend_len_reg[ADDR_W-1:0]),
        .wr_data (item.char_code),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule
